### rtl/core/ucr_pkg.sv
// ============================================================================
// ucr_pkg : shared types and constants of the ultrasonic echo ranger
// counter widths, register indexes, configuration and result records
// ============================================================================
package ucr_pkg;

    // width of the wait and pulse counters
    localparam int COUNT_WIDTH = 16;
    // width used for comparing counters against configuration values
    localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    // centimetre divisor and the running quotient and remainder widths
    localparam int CM_DIVISOR  = 58;
    localparam int REM_W       = $clog2(CM_DIVISOR);
    localparam int QUOT_W      = COUNT_WIDTH - $clog2(CM_DIVISOR) + 1;
    localparam int DIST_W      = 11;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd2;

    localparam logic [15:0] TIMEOUT_RST = 16'd30000;
    localparam logic [7:0]  TRIGGER_RST = 8'd10;
    localparam logic [7:0]  SETTLE_RST  = 8'd2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [REM_W-1:0]       REM_LAST = REM_W'(CM_DIVISOR - 1);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [QUOT_W-1:0]      quot_t;
    typedef logic [REM_W-1:0]       rem_t;

    typedef struct packed {
        logic [15:0] timeout_us;
        logic [7:0]  trigger_us;
        logic [7:0]  settle_us;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [DIST_W-1:0] distance_cm;
    } result_t;

    // saturating increment
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == CNT_MAX) ? CNT_MAX : v + count_t'(1);
        return r;
    endfunction

endpackage

### rtl/core/ucr_cfg_regs.sv
// ============================================================================
// ucr_cfg_regs : configuration register bank
// timeout, trigger width and settle time, written through a plain write port
// ============================================================================
module ucr_cfg_regs
    import ucr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us <= TIMEOUT_RST;
            cfg_reg.trigger_us <= TRIGGER_RST;
            cfg_reg.settle_us  <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: cfg_reg.timeout_us <= cfg_wdata;
                REG_TRIGGER: cfg_reg.trigger_us <= cfg_wdata[7:0];
                REG_SETTLE:  cfg_reg.settle_us  <= cfg_wdata[7:0];
                default:     ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/ucr_fsm.sv
// ============================================================================
// ucr_fsm : ranging sequencer
// trigger, echo waits and pulse measurement, one tick per step
// ============================================================================
module ucr_fsm
    import ucr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  logic    start_req,
    input  logic    echo_level,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SETTLE    = 3'd1;
    localparam logic [2:0] PH_TRIG      = 3'd2;
    localparam logic [2:0] PH_WAIT_LOW  = 3'd3;
    localparam logic [2:0] PH_WAIT_HIGH = 3'd4;
    localparam logic [2:0] PH_MEASURE   = 3'd5;

    logic [2:0] phase_reg, phase_next;
    count_t     wait_reg, wait_next;
    count_t     pulse_reg, pulse_next;
    // running pulse / 58, kept alongside the pulse counter
    quot_t      quot_reg, quot_next;
    rem_t       rem_reg, rem_next;

    count_t           wait_inc;
    count_t           pulse_inc;
    logic [CMP_W-1:0] wait_inc_x;
    logic [CMP_W-1:0] timeout_x;
    logic             wait_expired;
    logic             pulse_expired;
    logic             done;

    assign wait_inc      = sat_inc(wait_reg);
    assign pulse_inc     = sat_inc(pulse_reg);
    assign wait_inc_x    = CMP_W'(wait_inc);
    assign timeout_x     = CMP_W'(cfg.timeout_us);
    assign wait_expired  = (CMP_W'(wait_reg) >= timeout_x) || (wait_reg == CNT_MAX);
    assign pulse_expired = (CMP_W'(pulse_reg) >= timeout_x) || (pulse_reg == CNT_MAX);

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        pulse_next = pulse_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        done       = 1'b0;
        res        = '0;
        res.busy_res = 1'b1;

        case (phase_reg)
            PH_SETTLE:
            begin
                wait_next = wait_inc;
                if (wait_inc_x >= CMP_W'(cfg.settle_us))
                begin
                    phase_next = PH_TRIG;
                    wait_next  = '0;
                end
            end
            PH_TRIG:
            begin
                res.trigger_level = 1'b1;
                wait_next = wait_inc;
                if (wait_inc_x >= CMP_W'(cfg.trigger_us))
                begin
                    phase_next = PH_WAIT_LOW;
                    wait_next  = '0;
                end
            end
            PH_WAIT_LOW:
            begin
                if (!echo_level)
                begin
                    phase_next = PH_WAIT_HIGH;
                    wait_next  = wait_inc;
                end
                else if (wait_expired)
                begin
                    done          = 1'b1;
                    res.timed_out = 1'b1;
                end
                else
                begin
                    wait_next = wait_inc;
                end
            end
            PH_WAIT_HIGH:
            begin
                if (echo_level)
                begin
                    phase_next = PH_MEASURE;
                    pulse_next = count_t'(1);
                    quot_next  = '0;
                    rem_next   = rem_t'(1);
                end
                else if (wait_expired)
                begin
                    done          = 1'b1;
                    res.timed_out = 1'b1;
                end
                else
                begin
                    wait_next = wait_inc;
                end
            end
            PH_MEASURE:
            begin
                if (!echo_level)
                begin
                    done            = 1'b1;
                    res.distance_cm = DIST_W'(quot_reg);
                end
                else if (pulse_expired)
                begin
                    done          = 1'b1;
                    res.timed_out = 1'b1;
                end
                else
                begin
                    // not expired, so the counter is below its ceiling
                    pulse_next = pulse_inc;
                    if (rem_reg == REM_LAST)
                    begin
                        rem_next  = '0;
                        quot_next = quot_reg + quot_t'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg + rem_t'(1);
                    end
                end
            end
            default:
            begin
                res.busy_res = 1'b0;
                phase_next   = PH_IDLE;
                if (start_req)
                begin
                    wait_next  = '0;
                    pulse_next = '0;
                    phase_next = (cfg.settle_us == 8'd0) ? PH_TRIG : PH_SETTLE;
                end
            end
        endcase

        res.done_res = done;
        if (done)
        begin
            phase_next = PH_IDLE;
            wait_next  = '0;
            pulse_next = '0;
            quot_next  = '0;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            pulse_reg <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            pulse_reg <= pulse_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### rtl/core/ultrasonic_echo_ranger_core.sv
// ============================================================================
// ultrasonic_echo_ranger_core : ultrasonic echo ranging controller
// one tick in, one pin and status result out, distance in whole centimetres
// ============================================================================
//
// channel   direction  beats               contents
// s_axis    in         one per us tick     start request, echo level
// m_axis    out        one per input beat  trigger, busy, done, timeout, cm
// cfg       in         single-cycle write  timeout, trigger width, settle
//
// one transfer per clock sustained while m_axis takes every result; a tick's result
// passes through the input register, then the result register
// the sequencer steps only when the input register hands its tick on, so
// a stall on m_axis holds the sequencer state and backs up into s_axis
// reset puts the sequencer in idle and the config registers at their defaults
// the distance divide is a running quotient and remainder kept with the
// pulse counter, so no divider sits in the path
//
module ultrasonic_echo_ranger_core
    import ucr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] start_req, [1] echo_level, rest zero
    // result stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [0] trigger_level, [1] busy_res,
                                             // [2] done_res, [3] timed_out,
                                             // [14:4] distance_cm, [15] zero
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t res;

    // input register
    logic in_valid_reg;
    logic in_start_reg;
    logic in_echo_reg;

    // result register
    logic    out_valid_reg;
    result_t out_res_reg;

    logic out_free;
    logic advance;

    // the result slot frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    ucr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ucr_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .start_req  (in_start_reg),
        .echo_level (in_echo_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // tick payload, loaded on each incoming transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_start_reg <= s_tdata[0];
            in_echo_reg  <= s_tdata[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.distance_cm,
                       out_res_reg.timed_out,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.trigger_level};

endmodule

### sim/ultrasonic_echo_ranger_core_chk.sv
`timescale 1ns / 100ps
// ============================================================================
// ultrasonic_echo_ranger_core_chk : result checker for the echo ranger
// follows register writes and tick transfers, works out the pin and status
// result of every tick and compares it field by field with the result stream
// ============================================================================
module ultrasonic_echo_ranger_core_chk
    import ucr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    owed
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SETTLE,
        SEQ_PULSE,
        SEQ_ECHO_LOW,
        SEQ_ECHO_HIGH,
        SEQ_MEASURE
    } seq_t;

    seq_t        seq_phase;
    count_t      wait_cnt;
    count_t      pulse_cnt;
    logic [15:0] tmo_lim;
    logic [7:0]  trig_len;
    logic [7:0]  settle_len;

    result_t     due_results[$];

    initial mismatches = 0;

    function automatic count_t bump(input count_t v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic lapsed(input count_t c);
        return (c >= tmo_lim) || (c == CNT_MAX);
    endfunction

    // one microsecond of the ranging sequence
    function automatic result_t tick_ranger(input logic start, input logic echo);
        result_t r;
        r          = '0;
        r.busy_res = 1'b1;
        case (seq_phase)
            SEQ_SETTLE:
            begin
                wait_cnt = bump(wait_cnt);
                if (wait_cnt >= settle_len)
                begin
                    seq_phase = SEQ_PULSE;
                    wait_cnt  = '0;
                end
            end
            SEQ_PULSE:
            begin
                r.trigger_level = 1'b1;
                wait_cnt        = bump(wait_cnt);
                if (wait_cnt >= trig_len)
                begin
                    seq_phase = SEQ_ECHO_LOW;
                    wait_cnt  = '0;
                end
            end
            SEQ_ECHO_LOW:
            begin
                if (!echo)
                begin
                    seq_phase = SEQ_ECHO_HIGH;
                    wait_cnt  = bump(wait_cnt);
                end
                else if (lapsed(wait_cnt))
                begin
                    r.done_res  = 1'b1;
                    r.timed_out = 1'b1;
                end
                else
                    wait_cnt = bump(wait_cnt);
            end
            SEQ_ECHO_HIGH:
            begin
                if (echo)
                begin
                    seq_phase = SEQ_MEASURE;
                    pulse_cnt = count_t'(1);
                end
                else if (lapsed(wait_cnt))
                begin
                    r.done_res  = 1'b1;
                    r.timed_out = 1'b1;
                end
                else
                    wait_cnt = bump(wait_cnt);
            end
            SEQ_MEASURE:
            begin
                if (!echo)
                begin
                    r.done_res    = 1'b1;
                    r.distance_cm = DIST_W'(pulse_cnt / CM_DIVISOR);
                end
                else if (lapsed(pulse_cnt))
                begin
                    r.done_res  = 1'b1;
                    r.timed_out = 1'b1;
                end
                else
                    pulse_cnt = bump(pulse_cnt);
            end
            default:
            begin
                r.busy_res = 1'b0;
                seq_phase  = SEQ_IDLE;
                if (start)
                begin
                    wait_cnt  = '0;
                    pulse_cnt = '0;
                    seq_phase = (settle_len == 8'd0) ? SEQ_PULSE : SEQ_SETTLE;
                end
            end
        endcase
        if (r.done_res)
        begin
            seq_phase = SEQ_IDLE;
            wait_cnt  = '0;
            pulse_cnt = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            seq_phase  = SEQ_IDLE;
            wait_cnt   = '0;
            pulse_cnt  = '0;
            tmo_lim    = TIMEOUT_RST;
            trig_len   = TRIGGER_RST;
            settle_len = SETTLE_RST;
            due_results.delete();
            owed       = 0;
        end
        else
        begin
            // result side first, so a tick accepted at this edge never matches itself
            if (m_tvalid && m_tready)
            begin
                got.trigger_level = m_tdata[0];
                got.busy_res      = m_tdata[1];
                got.done_res      = m_tdata[2];
                got.timed_out     = m_tdata[3];
                got.distance_cm   = m_tdata[14:4];
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with none expected, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("trigger_level", want.trigger_level, got.trigger_level);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("distance_cm", want.distance_cm, got.distance_cm);
                end
            end
            // a write applies to the next tick the sequencer takes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIMEOUT: tmo_lim    = cfg_wdata[15:0];
                    REG_TRIGGER: trig_len   = cfg_wdata[7:0];
                    REG_SETTLE:  settle_len = cfg_wdata[7:0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                due_results.push_back(tick_ranger(s_tdata[0], s_tdata[1]));
            owed = due_results.size();
        end
    end

endmodule

### sim/ultrasonic_echo_ranger_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ultrasonic_echo_ranger_core_tb : testbench of the echo ranging core
// directed ranging sequences over the register extremes and timeout corners,
// then randomised sequences and noise under several settings, with random
// gaps on the tick stream and random stalls on the result stream
// ============================================================================
module ultrasonic_echo_ranger_core_tb;
    import ucr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int TOTAL_TICKS  = 1350;
    localparam int PHASES       = 8;
    localparam int QUIET_LIMIT  = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;      // [0] start_req, [1] echo_level, rest zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;      // [0] trigger_level, [1] busy_res, [2] done_res,
                                         // [3] timed_out, [14:4] distance_cm
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int owed;
    int quiet_cycles = 0;
    int tick_count   = 0;
    int hold_left    = 0;
    bit idling_on    = 1'b1;

    // register values as the stimulus sees them, used to shape the sequences
    int cur_timeout;
    int cur_trigger;
    int cur_settle;

    always #1 clk = ~clk;

    ultrasonic_echo_ranger_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ultrasonic_echo_ranger_core_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .owed       (owed)
    );

    // result side back-pressure: random stall bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            hold_left = $urandom_range(0, 9);
            m_tready  = 1'b0;
        end
        else
            m_tready = 1'b1;
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("ultrasonic_echo_ranger_core verification failed");
        $finish;
    end

    // one microsecond tick, preceded now and then by a random gap
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, echo, start};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tick_count++;
    endtask

    // stop the tick stream and let every owed result come out
    task automatic flush_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (owed != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_TIMEOUT: cur_timeout = value;
            REG_TRIGGER: cur_trigger = value[7:0];
            REG_SETTLE:  cur_settle  = value[7:0];
            default:     ;
        endcase
    endtask

    // 8 bit registers get junk in the upper bits, which the block must drop
    task automatic set_timing(input int timeout, input int trig, input int settle);
        flush_results();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(REG_TRIGGER, {8'($urandom), 8'(trig)});
        write_reg(REG_SETTLE, {8'($urandom), 8'(settle)});
    endtask

    // one ranging sequence: start, settle and trigger time with stray starts and echo noise,
    // echo held high, echo low, echo pulse, and optionally the falling echo edge
    task automatic range_once(input int lead_high, input int gap_low, input int pulse_len,
                              input bit ends_low);
        send_tick(1'b1, 1'($urandom));
        repeat (cur_settle + ((cur_trigger == 0) ? 1 : cur_trigger))
            send_tick(1'($urandom), 1'($urandom));
        repeat (lead_high) send_tick(1'b0, 1'b1);
        repeat (gap_low)   send_tick(1'b0, 1'b0);
        repeat (pulse_len) send_tick(1'b0, 1'b1);
        if (ends_low)
            send_tick(1'b0, 1'b0);
    endtask

    initial
    begin
        int budget_end;
        int lim;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        cur_timeout = TIMEOUT_RST;
        cur_trigger = TRIGGER_RST;
        cur_settle  = SETTLE_RST;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // idle ticks with echo noise, then one full measurement on reset values
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        range_once(3, 4, 116, 1'b1);

        // write to the unused register index must change nothing
        flush_results();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        range_once(1, 2, 60, 1'b1);

        // zero settle and zero trigger width, distance either side of 1 cm
        set_timing(200, 0, 0);
        range_once(0, 1, 57, 1'b1);
        range_once(2, 3, 58, 1'b1);

        // widest settle and trigger
        set_timing(200, 255, 255);
        range_once(1, 1, 5, 1'b1);

        // zero timeout: every wait and measure tick without its level expires
        set_timing(0, 1, 1);
        range_once(1, 0, 0, 1'b1);
        range_once(0, 2, 0, 1'b1);
        range_once(0, 1, 2, 1'b1);
        range_once(0, 1, 1, 1'b1);

        // short timeout on each of the two echo waits and on the pulse, and the pulse at its limit
        set_timing(5, 1, 0);
        range_once(10, 1, 1, 1'b1);
        range_once(0, 10, 1, 1'b1);
        range_once(0, 1, 6, 1'b1);
        range_once(0, 1, 5, 1'b1);

        // timeout cut down while a pulse is being measured
        set_timing(200, 3, 1);
        range_once(0, 2, 20, 1'b0);
        flush_results();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(5));
        send_tick(1'b0, 1'b1);

        // trigger width cut down while the trigger is high
        set_timing(200, 10, 1);
        send_tick(1'b1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0);
        flush_results();
        write_reg(REG_TRIGGER, CFG_DATA_W'(1));
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // widest timeout value with an ordinary measurement
        set_timing(65535, 1, 0);
        range_once(0, 1, 300, 1'b1);

        // ---- random part ----
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // last phase runs with both streams flat out
            if (ph == PHASES - 1)
            begin
                flush_results();
                idling_on = 1'b0;
                hold_left = 0;
            end
            if (ph == 0)
                set_timing(1, 1, 0);
            else if (ph == 1)
                set_timing($urandom_range(1, 120), $urandom_range(13, 40),
                           $urandom_range(9, 40));
            else if (ph % 3 == 2)
                set_timing($urandom_range(58, 200), $urandom_range(0, 12), $urandom_range(0, 8));
            else
                set_timing($urandom_range(1, 120), $urandom_range(0, 12), $urandom_range(0, 8));
            lim        = cur_timeout + 2;
            // share what is left of the tick budget over the remaining phases
            budget_end = tick_count + (TOTAL_TICKS - tick_count) / (PHASES - ph);
            do
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // noise: stray starts and echo chatter
                    repeat ($urandom_range(1, 12))
                        send_tick($urandom_range(0, 3) == 0, 1'($urandom));
                end
                else
                    range_once(($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                                           : $urandom_range(0, 2),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                                           : $urandom_range(1, 3),
                               $urandom_range(0, lim),
                               $urandom_range(0, 7) != 0);
            end
            while (tick_count < budget_end);
        end

        // ---- wind down ----
        flush_results();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && owed == 0)
            $display("ultrasonic_echo_ranger_core verification clean");
        else
            $display("ultrasonic_echo_ranger_core verification failed");
        $finish;
    end

endmodule
